/* rtl/core/lattice_sir_monte_carlo_step_top_defines.svh */
// Assertion macros shared by the lattice SIR step block.
`ifndef LATTICE_SIR_MONTE_CARLO_STEP_TOP_DEFINES_SVH
`define LATTICE_SIR_MONTE_CARLO_STEP_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LSIR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LSIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/lsir_pkg.sv */
// Shared constants and types of the lattice SIR step block.
package lsir_pkg;

    localparam int GRID_SIDE_DEF = 256;

    localparam int MODE_W     = 2;
    localparam int COORD_W    = 8;
    localparam int DIR_W      = 2;
    localparam int RAND_W     = 16;
    localparam int BOND_ROW_W = 9;
    localparam int LOAD_W     = 2;
    localparam int THR_W      = 17;
    localparam int COUNT_W    = 17;
    localparam int CFG_IDX_W  = 1;

    localparam logic [MODE_W-1:0] MODE_CELL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BOND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STEP = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 1'd1;

    localparam logic [THR_W-1:0] BETA_RST  = 17'd65536;
    localparam logic [THR_W-1:0] GAMMA_RST = 17'd13107;

    typedef struct packed {
        logic [THR_W-1:0] beta;
        logic [THR_W-1:0] gamma;
    } cfg_t;

    // Count adjustments for one cycle, and the end of a request.
    typedef struct packed {
        logic done;
        logic inf_inc;
        logic inf_dec;
        logic rec_inc;
        logic rec_dec;
    } tally_upd_t;

endpackage

/* rtl/core/lattice_sir_monte_carlo_step_top.sv */
// Top level of the lattice SIR step block: configuration, memories and sequencer.
//
// Requests are taken at a rising edge with start high and busy low. Mode selects a cell
// load, a barrier load or a step (one infection attempt from the source towards its
// neighbour, then one recovery attempt on a second cell); the unused mode changes nothing.
// Every request returns one result: the recovered and infected counts after it, shown
// on recovered_count and infected_count while done is high for exactly one cycle.
// The receiver cannot hold results off; the counts stay on the ports until the next
// request changes them.
// A step runs through sequencer states S1, S2 and S3, set by the single read port of the
// cell memory, which reads source, target and recovery cell in turn; a load runs through
// S1 only. done rises in the cycle after the last sequencer state, which is also the
// first cycle a new request can be accepted.
// Thresholds are written through cfg_we, cfg_index and cfg_data; the user is to write
// them only while no request runs, which the block itself does not enforce. After reset
// a clearing pass zeroes both memories, one entry a cycle; busy is high during it and
// configuration writes are still taken. Counts reset to zero and thresholds to their
// defaults.
module lattice_sir_monte_carlo_step_top #(
    parameter int GRID_SIDE = lsir_pkg::GRID_SIDE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    output logic                              done,
    input  logic [lsir_pkg::MODE_W-1:0]       mode,
    input  logic [lsir_pkg::COORD_W-1:0]      x_a,
    input  logic [lsir_pkg::COORD_W-1:0]      y_a,
    input  logic [lsir_pkg::DIR_W-1:0]        dir_a,
    input  logic [lsir_pkg::RAND_W-1:0]       rand_a,
    input  logic [lsir_pkg::COORD_W-1:0]      x_b,
    input  logic [lsir_pkg::COORD_W-1:0]      y_b,
    input  logic [lsir_pkg::RAND_W-1:0]       rand_b,
    input  logic [lsir_pkg::BOND_ROW_W-1:0]   bond_row,
    input  logic [lsir_pkg::LOAD_W-1:0]       load_value,
    output logic [lsir_pkg::COUNT_W-1:0]      recovered_count,
    output logic [lsir_pkg::COUNT_W-1:0]      infected_count,
    input  logic                              cfg_we,
    input  logic [lsir_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lsir_pkg::THR_W-1:0]        cfg_data
);
    import lsir_pkg::*;

    localparam int CW = $clog2(GRID_SIDE);

    logic [THR_W-1:0] beta_reg, gamma_reg;
    cfg_t             cfg;
    tally_upd_t       upd;

    logic             cell_we;
    logic [2*CW-1:0]  cell_waddr, cell_raddr;
    logic [1:0]       cell_wdata, cell_rdata;
    logic             bond_we, bond_wdata, bond_rdata;
    logic [2*CW:0]    bond_waddr, bond_raddr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_reg  <= BETA_RST;
            gamma_reg <= GAMMA_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_BETA)
            begin
                beta_reg <= cfg_data;
            end
            else if (cfg_index == CFG_GAMMA)
            begin
                gamma_reg <= cfg_data;
            end
        end
    end

    assign cfg.beta  = beta_reg;
    assign cfg.gamma = gamma_reg;

    lsir_ctrl #(
        .GRID_SIDE (GRID_SIDE),
        .CW        (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .x_a        (x_a),
        .y_a        (y_a),
        .dir_a      (dir_a),
        .rand_a     (rand_a),
        .x_b        (x_b),
        .y_b        (y_b),
        .rand_b     (rand_b),
        .bond_row   (bond_row),
        .load_value (load_value),
        .cfg        (cfg),
        .cell_we    (cell_we),
        .cell_waddr (cell_waddr),
        .cell_wdata (cell_wdata),
        .cell_raddr (cell_raddr),
        .cell_rdata (cell_rdata),
        .bond_we    (bond_we),
        .bond_waddr (bond_waddr),
        .bond_wdata (bond_wdata),
        .bond_raddr (bond_raddr),
        .bond_rdata (bond_rdata),
        .upd        (upd)
    );

    // Cells are addressed as {x, y}; barriers as {row, column}.
    lsir_ram #(
        .WIDTH (2),
        .DEPTH (1 << (2 * CW))
    ) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    lsir_ram #(
        .WIDTH (1),
        .DEPTH (1 << (2 * CW + 1))
    ) u_bond_ram (
        .clk   (clk),
        .we    (bond_we),
        .waddr (bond_waddr),
        .wdata (bond_wdata),
        .raddr (bond_raddr),
        .rdata (bond_rdata)
    );

    lsir_tally #(
        .GRID_SIDE (GRID_SIDE)
    ) u_tally (
        .clk             (clk),
        .rst_n           (rst_n),
        .upd             (upd),
        .done            (done),
        .recovered_count (recovered_count),
        .infected_count  (infected_count)
    );

endmodule

/* rtl/core/lsir_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module lsir_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/lsir_tally.sv */
// Running infected and recovered counts with saturated result outputs.
module lsir_tally #(
    parameter int GRID_SIDE = lsir_pkg::GRID_SIDE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  lsir_pkg::tally_upd_t           upd,
    output logic                           done,
    output logic [lsir_pkg::COUNT_W-1:0]   recovered_count,
    output logic [lsir_pkg::COUNT_W-1:0]   infected_count
);
    import lsir_pkg::*;

    `include "lattice_sir_monte_carlo_step_top_defines.svh"

    localparam int CNT_W = $clog2(GRID_SIDE * GRID_SIDE + 1);
    localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    logic [CNT_W-1:0] inf_cnt_reg, inf_cnt_next;
    logic [CNT_W-1:0] rec_cnt_reg, rec_cnt_next;
    logic             done_reg;
    logic [EXT_W-1:0] inf_ext, rec_ext;

    always_comb
    begin
        inf_cnt_next = inf_cnt_reg + CNT_W'(upd.inf_inc) - CNT_W'(upd.inf_dec);
        rec_cnt_next = rec_cnt_reg + CNT_W'(upd.rec_inc) - CNT_W'(upd.rec_dec);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inf_cnt_reg <= '0;
            rec_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            inf_cnt_reg <= inf_cnt_next;
            rec_cnt_reg <= rec_cnt_next;
            done_reg    <= upd.done;
        end
    end

    assign inf_ext = EXT_W'(inf_cnt_reg);
    assign rec_ext = EXT_W'(rec_cnt_reg);

    assign infected_count  = (inf_ext > EXT_W'(COUNT_MAX)) ? COUNT_MAX : inf_ext[COUNT_W-1:0];
    assign recovered_count = (rec_ext > EXT_W'(COUNT_MAX)) ? COUNT_MAX : rec_ext[COUNT_W-1:0];
    assign done            = done_reg;

    // Every cell is counted at most once.
    `LSIR_ASSERT_IMPL(a_count_bound, 1'b1,
        (CNT_W+1)'(inf_cnt_reg) + (CNT_W+1)'(rec_cnt_reg) <= (CNT_W+1)'(GRID_SIDE * GRID_SIDE),
        "infected plus recovered count exceeds the number of cells")
    // Every request passes through idle and S1 before it ends, so the result strobe falls between results.
    `LSIR_ASSERT_NEXT(a_done_single, done_reg, !done_reg,
        "result strobe held for more than one cycle")

endmodule

/* rtl/core/lsir_ctrl.sv */
// Request sequencer: memory addressing, infection and recovery decisions.
module lsir_ctrl #(
    parameter int GRID_SIDE = lsir_pkg::GRID_SIDE_DEF,
    parameter int CW        = $clog2(GRID_SIDE)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [lsir_pkg::MODE_W-1:0]       mode,
    input  logic [lsir_pkg::COORD_W-1:0]      x_a,
    input  logic [lsir_pkg::COORD_W-1:0]      y_a,
    input  logic [lsir_pkg::DIR_W-1:0]        dir_a,
    input  logic [lsir_pkg::RAND_W-1:0]       rand_a,
    input  logic [lsir_pkg::COORD_W-1:0]      x_b,
    input  logic [lsir_pkg::COORD_W-1:0]      y_b,
    input  logic [lsir_pkg::RAND_W-1:0]       rand_b,
    input  logic [lsir_pkg::BOND_ROW_W-1:0]   bond_row,
    input  logic [lsir_pkg::LOAD_W-1:0]       load_value,
    input  lsir_pkg::cfg_t                    cfg,
    output logic                              cell_we,
    output logic [2*CW-1:0]                   cell_waddr,
    output logic [1:0]                        cell_wdata,
    output logic [2*CW-1:0]                   cell_raddr,
    input  logic [1:0]                        cell_rdata,
    output logic                              bond_we,
    output logic [2*CW:0]                     bond_waddr,
    output logic                              bond_wdata,
    output logic [2*CW:0]                     bond_raddr,
    input  logic                              bond_rdata,
    output lsir_pkg::tally_upd_t              upd
);
    import lsir_pkg::*;

    `include "lattice_sir_monte_carlo_step_top_defines.svh"

    localparam int LUT_W    = 10;
    localparam int BROW_EXT = (CW + 1 > BOND_ROW_W) ? CW + 1 : BOND_ROW_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_S1    = 3'd2;
    localparam logic [2:0] ST_S2    = 3'd3;
    localparam logic [2:0] ST_S3    = 3'd4;

    localparam logic [DIR_W-1:0] DIR_YP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_XP = 2'd1;
    localparam logic [DIR_W-1:0] DIR_YM = 2'd2;
    localparam logic [DIR_W-1:0] DIR_XM = 2'd3;

    localparam logic [1:0] CELL_INFECTED  = 2'b01;
    localparam logic [1:0] CELL_RECOVERED = 2'b10;

    typedef logic [255:0][LUT_W-1:0] wrap_lut_t;

    // Residue of every input coordinate, built by counting so no divider appears.
    function automatic wrap_lut_t build_wrap(input int side);
        wrap_lut_t lut;
        int        r;
        r = 0;
        for (int c = 0; c < 256; c++)
        begin
            lut[c] = LUT_W'(r);
            r = r + 1;
            if (r == side)
            begin
                r = 0;
            end
        end
        return lut;
    endfunction

    localparam wrap_lut_t WRAP_LUT = build_wrap(GRID_SIDE);

    function automatic logic [CW-1:0] coord_inc(input logic [CW-1:0] c);
        return (c == CW'(GRID_SIDE - 1)) ? '0 : CW'(c + 1'b1);
    endfunction

    function automatic logic [CW-1:0] coord_dec(input logic [CW-1:0] c);
        return (c == '0) ? CW'(GRID_SIDE - 1) : CW'(c - 1'b1);
    endfunction

    logic [2:0]          state_reg, state_next;
    logic [2*CW:0]       clr_reg, clr_next;
    logic [MODE_W-1:0]   mode_reg;
    logic [CW-1:0]       xa_reg, ya_reg, xb_reg, yb_reg;
    logic [DIR_W-1:0]    dir_reg;
    logic [RAND_W-1:0]   ra_reg, rb_reg;
    logic                brow_ok_reg;
    logic [CW:0]         brow_reg;
    logic [LOAD_W-1:0]   lv_reg;
    logic                src_inf_reg;
    logic                infect_reg;

    logic                accept;
    logic [CW-1:0]       xa_in, ya_in;
    logic [BROW_EXT-1:0] brow_ext;
    logic [CW-1:0]       xt, yt;
    logic [CW:0]         bar_row;
    logic [CW-1:0]       bar_col;
    logic                infect;
    logic [1:0]          rec_val;
    logic                recover;
    logic                old_rec, new_rec;

    assign accept   = start && (state_reg == ST_IDLE);
    assign busy     = (state_reg != ST_IDLE);
    assign xa_in    = WRAP_LUT[x_a][CW-1:0];
    assign ya_in    = WRAP_LUT[y_a][CW-1:0];
    assign brow_ext = BROW_EXT'(bond_row);

    // Neighbour of the source on the torus.
    always_comb
    begin
        xt = xa_reg;
        yt = ya_reg;
        unique case (dir_reg)
            DIR_YP: yt = coord_inc(ya_reg);
            DIR_XP: xt = coord_inc(xa_reg);
            DIR_YM: yt = coord_dec(ya_reg);
            DIR_XM: xt = coord_dec(xa_reg);
        endcase
    end

    assign bar_row = (CW+1)'(xa_reg) + (CW+1)'(xt);
    assign bar_col = (ya_reg < yt) ? ya_reg : yt;

    // Target data arrives in S2, barrier bit likewise.
    assign infect = src_inf_reg && (cell_rdata == 2'b00) && !bond_rdata
                    && (cfg.beta > THR_W'(ra_reg));

    // The recovery cell was read while the target was being written.
    assign rec_val = (infect_reg && (xb_reg == xt) && (yb_reg == yt)) ? CELL_INFECTED
                                                                      : cell_rdata;
    assign recover = rec_val[0] && (cfg.gamma > THR_W'(rb_reg));

    assign old_rec = !cell_rdata[0] && cell_rdata[1];
    assign new_rec = !lv_reg[0] && lv_reg[1];

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_S1;
                end
            end
            ST_S1:   state_next = (mode_reg == MODE_STEP) ? ST_S2 : ST_IDLE;
            ST_S2:   state_next = ST_S3;
            ST_S3:   state_next = ST_IDLE;
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg    <= mode;
            xa_reg      <= xa_in;
            ya_reg      <= ya_in;
            dir_reg     <= dir_a;
            ra_reg      <= rand_a;
            xb_reg      <= WRAP_LUT[x_b][CW-1:0];
            yb_reg      <= WRAP_LUT[y_b][CW-1:0];
            rb_reg      <= rand_b;
            brow_ok_reg <= (32'(bond_row) < 32'(2 * GRID_SIDE));
            brow_reg    <= brow_ext[CW:0];
            lv_reg      <= load_value;
        end
        if (state_reg == ST_S1)
        begin
            src_inf_reg <= cell_rdata[0];
        end
        if (state_reg == ST_S2)
        begin
            infect_reg <= infect;
        end
    end

    // Cell memory: source read at acceptance, then target, then recovery cell.
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: cell_raddr = {xa_in, ya_in};
            ST_S1:   cell_raddr = {xt, yt};
            default: cell_raddr = {xb_reg, yb_reg};
        endcase
    end

    always_comb
    begin
        cell_we    = 1'b0;
        cell_waddr = {xb_reg, yb_reg};
        cell_wdata = CELL_RECOVERED;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cell_we    = 1'b1;
                cell_waddr = clr_reg[2*CW-1:0];
                cell_wdata = 2'b00;
            end
            ST_S1:
            begin
                cell_we    = (mode_reg == MODE_CELL);
                cell_waddr = {xa_reg, ya_reg};
                cell_wdata = lv_reg;
            end
            ST_S2:
            begin
                cell_we    = infect;
                cell_waddr = {xt, yt};
                cell_wdata = CELL_INFECTED;
            end
            ST_S3:
            begin
                cell_we = recover;
            end
            default:
            begin
                cell_we = 1'b0;
            end
        endcase
    end

    assign bond_raddr = {bar_row, bar_col};
    assign bond_we    = (state_reg == ST_CLEAR)
                        || ((state_reg == ST_S1) && (mode_reg == MODE_BOND) && brow_ok_reg);
    assign bond_waddr = (state_reg == ST_CLEAR) ? clr_reg : {brow_reg, ya_reg};
    assign bond_wdata = (state_reg != ST_CLEAR) && lv_reg[0];

    always_comb
    begin
        upd = '0;
        unique case (state_reg)
            ST_S1:
            begin
                upd.done = (mode_reg != MODE_STEP);
                if (mode_reg == MODE_CELL)
                begin
                    upd.inf_inc = lv_reg[0] && !cell_rdata[0];
                    upd.inf_dec = cell_rdata[0] && !lv_reg[0];
                    upd.rec_inc = new_rec && !old_rec;
                    upd.rec_dec = old_rec && !new_rec;
                end
            end
            ST_S2:
            begin
                upd.inf_inc = infect;
            end
            ST_S3:
            begin
                upd.done    = 1'b1;
                upd.inf_dec = recover;
                upd.rec_inc = recover;
            end
            default:
            begin
                upd = '0;
            end
        endcase
    end

    `LSIR_ASSERT_NEXT(a_accept_to_s1, accept, state_reg == ST_S1,
        "accepted request did not enter the sequencer")
    `LSIR_ASSERT_IMPL(a_clear_silent, state_reg == ST_CLEAR,
        !upd.done && (!cell_we || cell_wdata == 2'b00),
        "clearing pass produced a result or wrote a non-zero cell")
    `LSIR_ASSERT_NEXT(a_step_returns, state_reg == ST_S3, state_reg == ST_IDLE && !busy,
        "step request did not return to idle after recovery")

endmodule

/* tb/testbench.sv */
// Self-checking testbench of the lattice SIR step block, with a scoreboard that predicts the counts.
import lsir_pkg::*;

typedef enum logic [DIR_W-1:0] {
    DIR_Y_INC,
    DIR_X_INC,
    DIR_Y_DEC,
    DIR_X_DEC
} dir_code_t;

typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [COORD_W-1:0]    x_a;
    logic [COORD_W-1:0]    y_a;
    logic [DIR_W-1:0]      dir_a;
    logic [RAND_W-1:0]     rand_a;
    logic [COORD_W-1:0]    x_b;
    logic [COORD_W-1:0]    y_b;
    logic [RAND_W-1:0]     rand_b;
    logic [BOND_ROW_W-1:0] bond_row;
    logic [LOAD_W-1:0]     load_value;
} sir_request_t;

typedef struct packed {
    logic [COUNT_W-1:0] recovered;
    logic [COUNT_W-1:0] infected;
} count_pair_t;

class epidemic_scoreboard;
    localparam int SIDE = GRID_SIDE_DEF;
    localparam int unsigned COUNT_CEIL = 2**COUNT_W - 1;

    bit [1:0]         cell_state [SIDE*SIDE];
    bit               barrier [2*SIDE*SIDE];
    int unsigned      recovered_total;
    int unsigned      infected_total;
    logic [THR_W-1:0] beta;
    logic [THR_W-1:0] gamma;
    count_pair_t      awaited_counts [$];
    int               mismatch_count;

    function new();
        recovered_total = 0;
        infected_total  = 0;
        beta            = BETA_RST;
        gamma           = GAMMA_RST;
        mismatch_count  = 0;
    endfunction

    task report_mismatch(string msg);
        $display("ERROR: %s", msg);
        mismatch_count++;
    endtask

    function void set_threshold(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] value);
        if (idx == CFG_BETA)
            beta = value;
        else
            gamma = value;
    endfunction

    function int pending();
        return awaited_counts.size();
    endfunction

    // A cell with both bits set counts as infected only.
    function void store_cell(int unsigned idx, bit [1:0] value);
        if (cell_state[idx][0])
            infected_total--;
        else if (cell_state[idx][1])
            recovered_total--;
        if (value[0])
            infected_total++;
        else if (value[1])
            recovered_total++;
        cell_state[idx] = value;
    endfunction

    function void note_request(sir_request_t r);
        int unsigned xa;
        int unsigned ya;
        int unsigned xb;
        int unsigned yb;
        int unsigned xt;
        int unsigned yt;
        int unsigned col;
        int unsigned tidx;
        int unsigned ridx;
        bit [1:0]    src;
        bit [1:0]    tgt;
        count_pair_t predicted;
        xa = r.x_a % SIDE;
        ya = r.y_a % SIDE;
        xb = r.x_b % SIDE;
        yb = r.y_b % SIDE;
        case (r.mode)
            MODE_CELL: store_cell(xa * SIDE + ya, r.load_value);
            MODE_BOND:
            begin
                if (r.bond_row < 2 * SIDE)
                    barrier[r.bond_row * SIDE + ya] = r.load_value[0];
            end
            MODE_STEP:
            begin
                xt = xa;
                yt = ya;
                case (dir_code_t'(r.dir_a))
                    DIR_Y_INC: yt = (ya + 1) % SIDE;
                    DIR_X_INC: xt = (xa + 1) % SIDE;
                    DIR_Y_DEC: yt = (ya + SIDE - 1) % SIDE;
                    DIR_X_DEC: xt = (xa + SIDE - 1) % SIDE;
                endcase
                src  = cell_state[xa * SIDE + ya];
                tidx = xt * SIDE + yt;
                tgt  = cell_state[tidx];
                col  = (ya < yt) ? ya : yt;
                if (src[0] && tgt == 2'b00 && beta > r.rand_a && !barrier[(xa + xt) * SIDE + col])
                    store_cell(tidx, tgt | 2'b01);
                // The recovery test sees the cell as left by the infection attempt.
                ridx = xb * SIDE + yb;
                if (cell_state[ridx][0] && gamma > r.rand_b)
                    store_cell(ridx, 2'b10);
            end
            default: ;
        endcase
        predicted.recovered = COUNT_W'((recovered_total > COUNT_CEIL) ? COUNT_CEIL
                                                                        : recovered_total);
        predicted.infected  = COUNT_W'((infected_total > COUNT_CEIL) ? COUNT_CEIL
                                                                       : infected_total);
        awaited_counts.push_back(predicted);
    endfunction

    task check_result(logic [COUNT_W-1:0] rec, logic [COUNT_W-1:0] inf);
        count_pair_t want;
        if (awaited_counts.size() == 0)
        begin
            report_mismatch($sformatf("result with no request pending: recovered %0d infected %0d",
                                      rec, inf));
            return;
        end
        want = awaited_counts.pop_front();
        if (rec !== want.recovered)
            report_mismatch($sformatf("recovered_count %0d, predicted %0d", rec, want.recovered));
        if (inf !== want.infected)
            report_mismatch($sformatf("infected_count %0d, predicted %0d", inf, want.infected));
    endtask
endclass

module testbench;
    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 95;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   done;
    logic [MODE_W-1:0]      mode = '0;
    logic [COORD_W-1:0]     x_a = '0;
    logic [COORD_W-1:0]     y_a = '0;
    logic [DIR_W-1:0]       dir_a = '0;
    logic [RAND_W-1:0]      rand_a = '0;
    logic [COORD_W-1:0]     x_b = '0;
    logic [COORD_W-1:0]     y_b = '0;
    logic [RAND_W-1:0]      rand_b = '0;
    logic [BOND_ROW_W-1:0]  bond_row = '0;
    logic [LOAD_W-1:0]      load_value = '0;
    logic [COUNT_W-1:0]     recovered_count;
    logic [COUNT_W-1:0]     infected_count;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [THR_W-1:0]       cfg_data = '0;
    int                     cycle_count = 0;
    bit                     gaps_on = 1'b0;
    epidemic_scoreboard     tally;

    lattice_sir_monte_carlo_step_top dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            tally.check_result(recovered_count, infected_count);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_request(input sir_request_t r);
        mode       <= r.mode;
        x_a        <= r.x_a;
        y_a        <= r.y_a;
        dir_a      <= r.dir_a;
        rand_a     <= r.rand_a;
        x_b        <= r.x_b;
        y_b        <= r.y_b;
        rand_b     <= r.rand_b;
        bond_row   <= r.bond_row;
        load_value <= r.load_value;
        start      <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        tally.note_request(r);
    endtask

    task automatic issue(input logic [MODE_W-1:0] m, input int xa, input int ya,
                         input dir_code_t d, input int ra, input int xb, input int yb,
                         input int rb, input int brow, input int lv);
        sir_request_t r;
        r.mode       = m;
        r.x_a        = COORD_W'(xa);
        r.y_a        = COORD_W'(ya);
        r.dir_a      = d;
        r.rand_a     = RAND_W'(ra);
        r.x_b        = COORD_W'(xb);
        r.y_b        = COORD_W'(yb);
        r.rand_b     = RAND_W'(rb);
        r.bond_row   = BOND_ROW_W'(brow);
        r.load_value = LOAD_W'(lv);
        send_request(r);
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (tally.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_thresholds(input logic [THR_W-1:0] beta_v,
                                    input logic [THR_W-1:0] gamma_v);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BETA;
        cfg_data  <= beta_v;
        @(posedge clk);
        tally.set_threshold(CFG_BETA, beta_v);
        cfg_index <= CFG_GAMMA;
        cfg_data  <= gamma_v;
        @(posedge clk);
        tally.set_threshold(CFG_GAMMA, gamma_v);
        cfg_we    <= 1'b0;
    endtask

    // Most coordinates fall in a small patch across the wrap, so that cells interact.
    function automatic logic [COORD_W-1:0] near_corner();
        if ($urandom_range(0, 9) < 8)
            return COORD_W'(254 + $urandom_range(0, 4));
        return COORD_W'($urandom_range(0, 255));
    endfunction

    function automatic sir_request_t random_request();
        sir_request_t       r;
        int unsigned        k;
        logic [COORD_W-1:0] nb;
        k = $urandom_range(0, 99);
        r.mode = (k < 18) ? MODE_CELL : (k < 28) ? MODE_BOND : (k < 95) ? MODE_STEP : MODE_NOP;
        r.x_a        = near_corner();
        r.y_a        = near_corner();
        r.dir_a      = DIR_W'($urandom_range(0, 3));
        r.rand_a     = RAND_W'($urandom_range(0, 65535));
        r.x_b        = near_corner();
        r.y_b        = near_corner();
        r.rand_b     = RAND_W'($urandom_range(0, 65535));
        r.load_value = LOAD_W'($urandom_range(0, 3));
        // Barrier writes mostly hit rows that a step from the patch will read.
        nb = COORD_W'(int'(r.x_a) + int'($urandom_range(0, 2)) - 1);
        if ($urandom_range(0, 9) < 7)
            r.bond_row = BOND_ROW_W'(r.x_a) + BOND_ROW_W'(nb);
        else
            r.bond_row = BOND_ROW_W'($urandom_range(0, 511));
        return r;
    endfunction

    task automatic run_phase(input int items, input logic [THR_W-1:0] beta_v,
                             input logic [THR_W-1:0] gamma_v, input bit gaps);
        drain();
        write_thresholds(beta_v, gamma_v);
        gaps_on = gaps;
        repeat (items)
        begin
            if (gaps_on && $urandom_range(0, 99) < 15)
                pause_sender($urandom_range(1, 6));
            send_request(random_request());
        end
    endtask

    initial
    begin
        tally = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        write_thresholds(BETA_RST, GAMMA_RST);

        issue(MODE_CELL, 0, 0, DIR_Y_INC, 0, 0, 0, 0, 0, 1);
        issue(MODE_STEP, 0, 0, DIR_Y_DEC, 65535, 0, 255, 65535, 0, 0);
        issue(MODE_STEP, 0, 0, DIR_X_DEC, 0, 255, 0, 0, 0, 0);
        issue(MODE_BOND, 0, 0, DIR_Y_INC, 0, 0, 0, 0, 1, 1);
        issue(MODE_STEP, 0, 0, DIR_X_INC, 0, 0, 0, 13107, 0, 0);
        // Bit 0 clear lifts the barrier again.
        issue(MODE_BOND, 0, 0, DIR_Y_INC, 0, 0, 0, 0, 1, 2);
        issue(MODE_STEP, 0, 0, DIR_X_INC, 100, 1, 0, 13106, 0, 0);
        issue(MODE_CELL, 0, 1, DIR_Y_INC, 0, 0, 0, 0, 0, 3);
        issue(MODE_STEP, 0, 0, DIR_Y_INC, 0, 0, 1, 0, 0, 0);
        issue(MODE_CELL, 255, 255, DIR_Y_INC, 0, 0, 0, 0, 0, 1);
        issue(MODE_BOND, 0, 255, DIR_Y_INC, 0, 0, 0, 0, 509, 1);
        issue(MODE_STEP, 255, 255, DIR_X_DEC, 0, 254, 255, 65535, 0, 0);
        issue(MODE_STEP, 255, 255, DIR_Y_INC, 0, 255, 0, 65535, 0, 0);
        issue(MODE_CELL, 128, 128, DIR_Y_INC, 0, 0, 0, 0, 0, 2);
        issue(MODE_CELL, 128, 128, DIR_Y_INC, 0, 0, 0, 0, 0, 0);
        issue(MODE_NOP, 255, 255, DIR_X_DEC, 65535, 255, 255, 65535, 511, 3);
        issue(MODE_BOND, 255, 255, DIR_X_DEC, 65535, 255, 255, 65535, 511, 3);
        issue(MODE_STEP, 255, 255, DIR_X_INC, 0, 255, 255, 65535, 0, 0);
        issue(MODE_CELL, 0, 255, DIR_Y_INC, 0, 0, 0, 0, 0, 0);
        issue(MODE_STEP, 0, 0, DIR_Y_DEC, 65535, 0, 255, 65535, 0, 0);
        issue(MODE_STEP, 0, 0, DIR_Y_INC, 0, 0, 0, 0, 0, 0);

        run_phase(PHASE_ITEMS, 17'd131071, 17'd0, 1'b1);
        run_phase(PHASE_ITEMS, 17'd0, 17'd65536, 1'b1);
        run_phase(PHASE_ITEMS, 17'd40000, 17'd20000, 1'b0);
        run_phase(PHASE_ITEMS, THR_W'($urandom_range(0, 131071)),
                  THR_W'($urandom_range(0, 131071)), 1'b1);
        run_phase(PHASE_ITEMS, 17'd65535, 17'd1, 1'b1);

        drain();
        repeat (8) @(posedge clk);
        if (tally.mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
